[design/tbgc_pkg.sv]
package tbgc_pkg;

  localparam int unsigned TimeWidth   = 32;
  localparam int unsigned CfgWidth    = 16;
  localparam int unsigned CfgIdxWidth = 1;

  localparam logic [CfgWidth-1:0] HOLD_TIMEOUT_RESET    = 16'd250;
  localparam logic [CfgWidth-1:0] DEBOUNCE_WINDOW_RESET = 16'd100;

  localparam logic [CfgIdxWidth-1:0] REG_HOLD_TIMEOUT    = 1'd0;
  localparam logic [CfgIdxWidth-1:0] REG_DEBOUNCE_WINDOW = 1'd1;

  localparam logic [2:0] GESTURE_NONE     = 3'd0;
  localparam logic [2:0] GESTURE_SINGLE_A = 3'd1;
  localparam logic [2:0] GESTURE_DOUBLE_A = 3'd2;
  localparam logic [2:0] GESTURE_HOLD     = 3'd3;
  localparam logic [2:0] GESTURE_SINGLE_B = 3'd4;
  localparam logic [2:0] GESTURE_DOUBLE_B = 3'd5;

  typedef struct packed {
    logic                 held_a;
    logic                 held_b;
    logic [TimeWidth-1:0] pending;
    logic [TimeWidth-1:0] dstart;
  } state_t;

  typedef struct packed {
    logic [TimeWidth-1:0] time_ms;
    logic                 level_a;
    logic                 level_b;
  } sample_t;

  typedef struct packed {
    logic [CfgWidth-1:0] hold_timeout;
    logic [CfgWidth-1:0] debounce_window;
  } cfg_t;

endpackage

[design/tbgc_if.sv]
interface tbgc_sample_if;
  logic        valid;
  logic        ready;
  logic [31:0] time_ms;
  logic        level_a;
  logic        level_b;

  modport source(output valid, output time_ms, output level_a, output level_b, input ready);
  modport sink(input valid, input time_ms, input level_a, input level_b, output ready);
endinterface

interface tbgc_gesture_if;
  logic       valid;
  logic       ready;
  logic [2:0] gesture;

  modport source(output valid, output gesture, input ready);
  modport sink(input valid, input gesture, output ready);
endinterface

[design/tbgc_eval.sv]
module tbgc_eval (
  input  tbgc_pkg::state_t  state,
  input  tbgc_pkg::sample_t sample,
  input  tbgc_pkg::cfg_t    cfg,
  output tbgc_pkg::state_t  state_next,
  output logic [2:0]        gesture
);

  logic [tbgc_pkg::TimeWidth-1:0] since_press;
  logic [tbgc_pkg::TimeWidth-1:0] since_change;
  logic                           hold;
  logic                           in_window;
  logic                           chg_a;
  logic                           chg_b;
  logic                           window_zero;
  logic                           press_pending;
  logic [tbgc_pkg::TimeWidth-1:0] press_time;

  assign since_press   = sample.time_ms - state.pending;
  assign since_change  = sample.time_ms - state.dstart;
  assign press_pending = (state.pending != '0);
  assign hold          = press_pending &&
                         (since_press > {{(tbgc_pkg::TimeWidth-tbgc_pkg::CfgWidth){1'b0}},
                                         cfg.hold_timeout});
  assign in_window     = since_change <
                         {{(tbgc_pkg::TimeWidth-tbgc_pkg::CfgWidth){1'b0}},
                          cfg.debounce_window};
  assign window_zero   = (cfg.debounce_window == '0);
  assign chg_a         = (state.held_a != sample.level_a);
  assign chg_b         = (state.held_b != sample.level_b);
  // a press at time zero still has to count as pending
  assign press_time    = (sample.time_ms == '0) ? {{(tbgc_pkg::TimeWidth-1){1'b0}}, 1'b1}
                                                 : sample.time_ms;

  always_comb begin
    state_next = state;
    gesture    = tbgc_pkg::GESTURE_NONE;
    if (hold) begin
      state_next.pending = '0;
      gesture            = tbgc_pkg::GESTURE_HOLD;
    end else if (chg_a) begin
      if (!in_window) begin
        state_next.dstart = sample.time_ms;
        state_next.held_a = sample.level_a;
        if (!sample.level_a) begin
          if (press_pending) begin
            state_next.pending = '0;
            gesture            = tbgc_pkg::GESTURE_DOUBLE_A;
          end else begin
            state_next.pending = press_time;
            gesture            = tbgc_pkg::GESTURE_SINGLE_A;
          end
        end else if (chg_b && window_zero) begin
          // release of A restarted the window, so B passes only with no window
          state_next.held_b = sample.level_b;
          if (!sample.level_b) begin
            if (press_pending) begin
              state_next.pending = '0;
              gesture            = tbgc_pkg::GESTURE_DOUBLE_B;
            end else begin
              state_next.pending = press_time;
              gesture            = tbgc_pkg::GESTURE_SINGLE_B;
            end
          end
        end
      end
    end else if (chg_b && !in_window) begin
      state_next.dstart = sample.time_ms;
      state_next.held_b = sample.level_b;
      if (!sample.level_b) begin
        if (press_pending) begin
          state_next.pending = '0;
          gesture            = tbgc_pkg::GESTURE_DOUBLE_B;
        end else begin
          state_next.pending = press_time;
          gesture            = tbgc_pkg::GESTURE_SINGLE_B;
        end
      end
    end
  end

endmodule

[design/two_button_gesture_classifier_core.sv]
// Path: a request taken into the sample register is evaluated, and its gesture
// is loaded into the output register once the output register is free to take it.
// Throughput: one sample per cycle while the gesture output is not stalled.
// The output register lets a new sample enter while a gesture waits.
// Reset (rst, synchronous): both buttons released, no press pending,
// debounce start 0, hold timeout 250 ms, debounce window 100 ms.
module two_button_gesture_classifier_core (
  input  logic                                clk,
  input  logic                                rst,
  tbgc_sample_if.sink                         samples,
  tbgc_gesture_if.source                      gestures,
  input  logic                                cfg_we,
  input  logic [tbgc_pkg::CfgIdxWidth-1:0]    cfg_index,
  input  logic [tbgc_pkg::CfgWidth-1:0]       cfg_data
);

  tbgc_pkg::cfg_t    cfg;
  tbgc_pkg::state_t  state;
  tbgc_pkg::state_t  state_next;
  tbgc_pkg::sample_t sample;
  logic              sample_valid;
  logic [2:0]        code;
  logic              out_valid;
  logic [2:0]        out_gesture;
  logic              advance;

  assign advance          = sample_valid && (!out_valid || gestures.ready);
  assign samples.ready    = !sample_valid || advance;
  assign gestures.valid   = out_valid;
  assign gestures.gesture = out_gesture;

  tbgc_eval u_eval (
    .state      (state),
    .sample     (sample),
    .cfg        (cfg),
    .state_next (state_next),
    .gesture    (code)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hold_timeout    <= tbgc_pkg::HOLD_TIMEOUT_RESET;
      cfg.debounce_window <= tbgc_pkg::DEBOUNCE_WINDOW_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tbgc_pkg::REG_HOLD_TIMEOUT:    cfg.hold_timeout    <= cfg_data;
        tbgc_pkg::REG_DEBOUNCE_WINDOW: cfg.debounce_window <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid  <= 1'b0;
      out_valid     <= 1'b0;
      state.held_a  <= 1'b1;
      state.held_b  <= 1'b1;
      state.pending <= '0;
      state.dstart  <= '0;
    end else begin
      if (samples.valid && samples.ready) begin
        sample_valid <= 1'b1;
      end else if (advance) begin
        sample_valid <= 1'b0;
      end
      if (advance) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (gestures.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers: hold while stalled
  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      sample.time_ms <= samples.time_ms;
      sample.level_a <= samples.level_a;
      sample.level_b <= samples.level_b;
    end
    if (advance) begin
      out_gesture <= code;
    end
  end

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_gesture <= tbgc_pkg::GESTURE_DOUBLE_B))
    else $error("gesture code out of range");

  a_hold_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && code == tbgc_pkg::GESTURE_HOLD) |=> (state.pending == '0))
    else $error("pending press not cleared after hold");

  a_single_pends: assert property (@(posedge clk) disable iff (rst)
    (advance && (code == tbgc_pkg::GESTURE_SINGLE_A || code == tbgc_pkg::GESTURE_SINGLE_B))
    |=> (state.pending != '0))
    else $error("single press left no pending press");

  a_sample_kept: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && !advance) |=> (sample_valid && $stable(sample)))
    else $error("stalled sample lost");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state))
    else $error("state changed without a sample");

endmodule
